@@ rtl/hsl_pkg.sv @@
// Shared widths, constants and types for the HSL to RGB pipeline.
`timescale 1ns / 1ps
package hsl_pkg;

	// Field widths
	localparam int HUE_W = 9;
	localparam int PCT_W = 7;
	localparam int LVL_W = 8;

	// Input ranges and output ceiling
	localparam int HUE_MAX = 360;
	localparam int PCT_MAX = 100;
	localparam int LVL_MAX = 255;

	// Pipeline depth, one enable per stage
	localparam int NUM_STAGES = 8;
	typedef logic [NUM_STAGES:1] stage_en_t;

	// Remainder products and their reciprocal divides (exact for these ranges)
	localparam int HUE_Y_W    = 17;
	localparam int HUE_RCP_SH = 26;
	localparam int HUE_RCP_W  = 18;
	localparam int HUE_RCP_M  = ((1 << HUE_RCP_SH) + HUE_MAX - 1) / HUE_MAX;
	localparam int PCT_Y_W    = 14;
	localparam int PCT_RCP_SH = 21;
	localparam int PCT_RCP_W  = 15;
	localparam int PCT_RCP_M  = ((1 << PCT_RCP_SH) + PCT_MAX - 1) / PCT_MAX;

	// Segment of the piecewise hue function
	typedef enum logic [1:0] {
		SEG_RISE,
		SEG_TOP,
		SEG_FALL,
		SEG_BASE
	} seg_t;

endpackage

@@ rtl/hsl_in_if.sv @@
// Input channel: one HSL color per transfer.
`timescale 1ns / 1ps
interface hsl_in_if;
	logic                        valid;
	logic                        ready;
	logic [hsl_pkg::HUE_W-1:0]   hue_degrees;
	logic [hsl_pkg::PCT_W-1:0]   saturation_pct;
	logic [hsl_pkg::PCT_W-1:0]   lightness_pct;

	modport source (output valid, hue_degrees, saturation_pct, lightness_pct, input ready);
	modport sink (input valid, hue_degrees, saturation_pct, lightness_pct, output ready);
endinterface

@@ rtl/hsl_out_if.sv @@
// Output channel: one RGB color per transfer.
`timescale 1ns / 1ps
interface hsl_out_if;
	logic                        valid;
	logic                        ready;
	logic [hsl_pkg::LVL_W-1:0]   red_level;
	logic [hsl_pkg::LVL_W-1:0]   green_level;
	logic [hsl_pkg::LVL_W-1:0]   blue_level;

	modport source (output valid, red_level, green_level, blue_level, input ready);
	modport sink (input valid, red_level, green_level, blue_level, output ready);
endinterface

@@ rtl/hsl_pipe_ctrl.sv @@
// Valid bits and per-stage enables of the conversion pipeline.
`timescale 1ns / 1ps
module hsl_pipe_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  out_ready,
	output hsl_pkg::stage_en_t    en,
	output logic                  out_valid
);

	logic [hsl_pkg::NUM_STAGES:1] vld_q;
	logic [hsl_pkg::NUM_STAGES:1] vld_d;

	// A stage moves when it is empty or the next one moves
	always_comb begin
		en[hsl_pkg::NUM_STAGES] = !vld_q[hsl_pkg::NUM_STAGES] || out_ready;
		for (int k = hsl_pkg::NUM_STAGES - 1; k >= 1; k--) begin
			en[k] = !vld_q[k] || en[k + 1];
		end
	end

	always_comb begin
		vld_d[1] = en[1] ? in_valid : vld_q[1];
		for (int k = 2; k <= hsl_pkg::NUM_STAGES; k++) begin
			vld_d[k] = en[k] ? vld_q[k - 1] : vld_q[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= vld_d;
		end
	end

	assign out_valid = vld_q[hsl_pkg::NUM_STAGES];

endmodule

@@ rtl/hsl_frac.sv @@
// Stages 1-2: clamp inputs and scale them to fixed-point fractions of one.
`timescale 1ns / 1ps
module hsl_frac #(
	parameter int FRAC_BITS = 16
) (
	input  logic                         clk,
	input  hsl_pkg::stage_en_t           en,
	input  logic [hsl_pkg::HUE_W-1:0]    hue_degrees,
	input  logic [hsl_pkg::PCT_W-1:0]    saturation_pct,
	input  logic [hsl_pkg::PCT_W-1:0]    lightness_pct,
	output logic [FRAC_BITS:0]           h_s2,
	output logic [FRAC_BITS:0]           s_s2,
	output logic [FRAC_BITS:0]           l_s2
);

	localparam int FW    = FRAC_BITS + 1;
	localparam int ONE   = 1 << FRAC_BITS;
	localparam int HUE_A = ONE / hsl_pkg::HUE_MAX;
	localparam int HUE_B = ONE % hsl_pkg::HUE_MAX;
	localparam int PCT_A = ONE / hsl_pkg::PCT_MAX;
	localparam int PCT_B = ONE % hsl_pkg::PCT_MAX;
	localparam int HUE_P_W = hsl_pkg::HUE_Y_W + hsl_pkg::HUE_RCP_W;
	localparam int PCT_P_W = hsl_pkg::PCT_Y_W + hsl_pkg::PCT_RCP_W;

	logic [hsl_pkg::HUE_W-1:0]   hue_c;
	logic [hsl_pkg::PCT_W-1:0]   sat_c;
	logic [hsl_pkg::PCT_W-1:0]   lig_c;

	logic [FW-1:0]               hxa_s1, sxa_s1, lxa_s1;
	logic [hsl_pkg::HUE_Y_W-1:0] hy_s1;
	logic [hsl_pkg::PCT_Y_W-1:0] sy_s1, ly_s1;

	logic [HUE_P_W-1:0]          hq;
	logic [PCT_P_W-1:0]          sq, lq;

	assign hue_c = (hue_degrees > hsl_pkg::HUE_W'(hsl_pkg::HUE_MAX)) ?
		hsl_pkg::HUE_W'(hsl_pkg::HUE_MAX) : hue_degrees;
	assign sat_c = (saturation_pct > hsl_pkg::PCT_W'(hsl_pkg::PCT_MAX)) ?
		hsl_pkg::PCT_W'(hsl_pkg::PCT_MAX) : saturation_pct;
	assign lig_c = (lightness_pct > hsl_pkg::PCT_W'(hsl_pkg::PCT_MAX)) ?
		hsl_pkg::PCT_W'(hsl_pkg::PCT_MAX) : lightness_pct;

	// x*ONE/d = x*floor(ONE/d) + floor(x*(ONE mod d)/d)
	always_ff @(posedge clk) begin
		if (en[1]) begin
			hxa_s1 <= FW'(hue_c) * FW'(HUE_A);
			sxa_s1 <= FW'(sat_c) * FW'(PCT_A);
			lxa_s1 <= FW'(lig_c) * FW'(PCT_A);
			hy_s1  <= hsl_pkg::HUE_Y_W'(hue_c) * hsl_pkg::HUE_Y_W'(HUE_B);
			sy_s1  <= hsl_pkg::PCT_Y_W'(sat_c) * hsl_pkg::PCT_Y_W'(PCT_B);
			ly_s1  <= hsl_pkg::PCT_Y_W'(lig_c) * hsl_pkg::PCT_Y_W'(PCT_B);
		end
	end

	// Remainder divide by reciprocal multiply
	assign hq = HUE_P_W'(hy_s1) * HUE_P_W'(hsl_pkg::HUE_RCP_M);
	assign sq = PCT_P_W'(sy_s1) * PCT_P_W'(hsl_pkg::PCT_RCP_M);
	assign lq = PCT_P_W'(ly_s1) * PCT_P_W'(hsl_pkg::PCT_RCP_M);

	always_ff @(posedge clk) begin
		if (en[2]) begin
			h_s2 <= hxa_s1 + FW'(hq[HUE_P_W-1:hsl_pkg::HUE_RCP_SH]);
			s_s2 <= sxa_s1 + FW'(sq[PCT_P_W-1:hsl_pkg::PCT_RCP_SH]);
			l_s2 <= lxa_s1 + FW'(lq[PCT_P_W-1:hsl_pkg::PCT_RCP_SH]);
		end
	end

endmodule

@@ rtl/hsl_qp.sv @@
// Stages 3-6: q and p from lightness and saturation, and their span.
`timescale 1ns / 1ps
module hsl_qp #(
	parameter int FRAC_BITS = 16
) (
	input  logic                   clk,
	input  hsl_pkg::stage_en_t     en,
	input  logic [FRAC_BITS:0]     s_s2,
	input  logic [FRAC_BITS:0]     l_s2,
	output logic [FRAC_BITS+1:0]   span_s5,
	output logic [FRAC_BITS+1:0]   p_s6,
	output logic [FRAC_BITS+1:0]   q_s6
);

	localparam int FW   = FRAC_BITS + 1;
	localparam int QW   = FRAC_BITS + 2;
	localparam int SW   = FRAC_BITS + 3;
	localparam int PW   = 2 * FW;
	localparam int HALF = (1 << FRAC_BITS) / 2;

	logic [PW-1:0]        ls_prod;
	logic [FW-1:0]        ls_s3, l_s3, s_s3, l_s4;
	logic [QW-1:0]        qraw_s4;
	logic signed [SW-1:0] praw;
	logic [QW-1:0]        p_c, q_c;
	logic [QW-1:0]        p_s5, q_s5;

	assign ls_prod = PW'(l_s2) * PW'(s_s2);

	always_ff @(posedge clk) begin
		if (en[3]) begin
			ls_s3 <= ls_prod[PW-2:FRAC_BITS];
			l_s3  <= l_s2;
			s_s3  <= s_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en[4]) begin
			if (l_s3 < FW'(HALF)) begin
				qraw_s4 <= QW'(l_s3) + QW'(ls_s3);
			end else begin
				qraw_s4 <= QW'(l_s3) + QW'(s_s3) - QW'(ls_s3);
			end
			l_s4 <= l_s3;
		end
	end

	// p = 2l - q, floored at zero; q never below p
	assign praw = $signed(SW'(l_s4) << 1) - $signed(SW'(qraw_s4));
	assign p_c  = praw[SW-1] ? '0 : praw[QW-1:0];
	assign q_c  = (qraw_s4 < p_c) ? p_c : qraw_s4;

	always_ff @(posedge clk) begin
		if (en[5]) begin
			p_s5    <= p_c;
			q_s5    <= q_c;
			span_s5 <= q_c - p_c;
		end
	end

	always_ff @(posedge clk) begin
		if (en[6]) begin
			p_s6 <= p_s5;
			q_s6 <= q_s5;
		end
	end

endmodule

@@ rtl/hsl_chan.sv @@
// Stages 3-8 of one color channel: hue offset, segment, scale and level.
`timescale 1ns / 1ps
module hsl_chan #(
	parameter int FRAC_BITS = 16,
	parameter int HUE_DIR   = 0
) (
	input  logic                          clk,
	input  hsl_pkg::stage_en_t            en,
	input  logic [FRAC_BITS:0]            h_s2,
	input  logic [FRAC_BITS+1:0]          span_s5,
	input  logic [FRAC_BITS+1:0]          p_s6,
	input  logic [FRAC_BITS+1:0]          q_s6,
	output logic [hsl_pkg::LVL_W-1:0]     lvl_s8
);

	localparam int FW     = FRAC_BITS + 1;
	localparam int VW     = FRAC_BITS + 2;
	localparam int TW     = FRAC_BITS + 3;
	localparam int XW     = FRAC_BITS + 4;
	localparam int PW     = VW + FW;
	localparam int LW     = FRAC_BITS + 10;
	localparam int ONE    = 1 << FRAC_BITS;
	localparam int THIRD  = ONE / 3;
	localparam int THIRD2 = (2 * ONE) / 3;
	localparam logic signed [TW-1:0] T_OFS = TW'(HUE_DIR * THIRD);
	localparam logic signed [TW-1:0] T_ONE = TW'(ONE);

	logic signed [TW-1:0]       t_raw, t_wrap;
	logic [FW-1:0]              t_s3;
	logic [XW-1:0]              t2, t3, t6, d, d6;
	hsl_pkg::seg_t              seg_c, seg_s4, seg_s5, seg_s6;
	logic [FW-1:0]              fac_s4, fac_s5;
	logic [PW-1:0]              prod;
	logic [VW-1:0]              prod_s6;
	logic [VW-1:0]              v_c, v_s7;
	logic [LW-1:0]              scaled;
	logic [LW-FRAC_BITS-1:0]    lvl_c;

	// Offset hue, wrapped into 0..ONE
	assign t_raw = $signed({2'b00, h_s2}) + T_OFS;
	always_comb begin
		t_wrap = t_raw;
		if (t_raw < 0) begin
			t_wrap = t_raw + T_ONE;
		end else if (t_raw > T_ONE) begin
			t_wrap = t_raw - T_ONE;
		end
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			t_s3 <= t_wrap[FW-1:0];
		end
	end

	assign t2 = XW'(t_s3) << 1;
	assign t3 = t2 + XW'(t_s3);
	assign t6 = t3 << 1;
	assign d  = XW'(THIRD2) - XW'(t_s3);
	assign d6 = (d << 2) + (d << 1);

	always_comb begin
		if (t6 < XW'(ONE)) begin
			seg_c = hsl_pkg::SEG_RISE;
		end else if (t2 < XW'(ONE)) begin
			seg_c = hsl_pkg::SEG_TOP;
		end else if (t3 < XW'(2 * ONE)) begin
			seg_c = hsl_pkg::SEG_FALL;
		end else begin
			seg_c = hsl_pkg::SEG_BASE;
		end
	end

	always_ff @(posedge clk) begin
		if (en[4]) begin
			seg_s4 <= seg_c;
			fac_s4 <= (seg_c == hsl_pkg::SEG_RISE) ? t6[FW-1:0] : d6[FW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en[5]) begin
			seg_s5 <= seg_s4;
			fac_s5 <= fac_s4;
		end
	end

	assign prod = PW'(span_s5) * PW'(fac_s5);

	always_ff @(posedge clk) begin
		if (en[6]) begin
			seg_s6  <= seg_s5;
			prod_s6 <= prod[FRAC_BITS+VW-1:FRAC_BITS];
		end
	end

	always_comb begin
		case (seg_s6)
			hsl_pkg::SEG_RISE: v_c = p_s6 + prod_s6;
			hsl_pkg::SEG_FALL: v_c = p_s6 + prod_s6;
			hsl_pkg::SEG_TOP:  v_c = q_s6;
			default:           v_c = p_s6;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en[7]) begin
			v_s7 <= v_c;
		end
	end

	// v * 255 / ONE, saturated
	assign scaled = (LW'(v_s7) << 8) - LW'(v_s7);
	assign lvl_c  = scaled[LW-1:FRAC_BITS];

	always_ff @(posedge clk) begin
		if (en[8]) begin
			lvl_s8 <= (lvl_c > (LW - FRAC_BITS)'(hsl_pkg::LVL_MAX)) ?
				hsl_pkg::LVL_W'(hsl_pkg::LVL_MAX) : lvl_c[hsl_pkg::LVL_W-1:0];
		end
	end

endmodule

@@ rtl/hsl_to_rgb_converter_top.sv @@
// Top level of the HSL to RGB color converter.
`timescale 1ns / 1ps
// Converts one HSL color (hue 0..360 degrees, saturation and lightness 0..100
// percent; larger codes clamp to the top of range) into 8-bit red, green and
// blue levels, truncated toward zero, using unsigned fixed point with
// FRAC_BITS fractional bits. Throughput is one color per clock when rgb does
// not stall the output. The result passes through the eight register stages
// of the pipeline (scale, divide, l*s product, q, p and span, span*slope
// product, channel value, 255 scaling); the first stage loads at the input
// transfer edge itself. Each stage holds its own valid bit and moves whenever
// it is empty or the stage after it moves, so bubbles close up and new colors
// are still taken while a finished result waits on rgb, as long as a stage is
// empty. hsl.ready is a combinational function of rgb.ready and the stage
// valid bits. There is no configuration and no state beyond the pipeline
// itself.
module hsl_to_rgb_converter_top #(
	parameter int FRAC_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	hsl_in_if.sink            hsl,
	hsl_out_if.source         rgb
);

	localparam int FW = FRAC_BITS + 1;
	localparam int VW = FRAC_BITS + 2;

	hsl_pkg::stage_en_t en;

	// Fractions of one after stage 2
	logic [FW-1:0] h_s2, s_s2, l_s2;

	// Shared q/p results feeding all three channels
	logic [VW-1:0] span_s5, p_s6, q_s6;

	hsl_pipe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (hsl.valid),
		.out_ready (rgb.ready),
		.en        (en),
		.out_valid (rgb.valid)
	);

	// Transfer is taken whenever the first stage can move
	assign hsl.ready = en[1];

	hsl_frac #(.FRAC_BITS(FRAC_BITS)) u_frac (
		.clk            (clk),
		.en             (en),
		.hue_degrees    (hsl.hue_degrees),
		.saturation_pct (hsl.saturation_pct),
		.lightness_pct  (hsl.lightness_pct),
		.h_s2           (h_s2),
		.s_s2           (s_s2),
		.l_s2           (l_s2)
	);

	hsl_qp #(.FRAC_BITS(FRAC_BITS)) u_qp (
		.clk     (clk),
		.en      (en),
		.s_s2    (s_s2),
		.l_s2    (l_s2),
		.span_s5 (span_s5),
		.p_s6    (p_s6),
		.q_s6    (q_s6)
	);

	// Red at h + 1/3, green at h, blue at h - 1/3.
	// Zero saturation needs no separate path: q = p = l gives gray.
	hsl_chan #(.FRAC_BITS(FRAC_BITS), .HUE_DIR(1)) u_red (
		.clk     (clk),
		.en      (en),
		.h_s2    (h_s2),
		.span_s5 (span_s5),
		.p_s6    (p_s6),
		.q_s6    (q_s6),
		.lvl_s8  (rgb.red_level)
	);

	hsl_chan #(.FRAC_BITS(FRAC_BITS), .HUE_DIR(0)) u_green (
		.clk     (clk),
		.en      (en),
		.h_s2    (h_s2),
		.span_s5 (span_s5),
		.p_s6    (p_s6),
		.q_s6    (q_s6),
		.lvl_s8  (rgb.green_level)
	);

	hsl_chan #(.FRAC_BITS(FRAC_BITS), .HUE_DIR(-1)) u_blue (
		.clk     (clk),
		.en      (en),
		.h_s2    (h_s2),
		.span_s5 (span_s5),
		.p_s6    (p_s6),
		.q_s6    (q_s6),
		.lvl_s8  (rgb.blue_level)
	);

endmodule

@@ rtl/hsl_checker.sv @@
// Port-level assertions for the HSL to RGB converter, bound to the top level.
`timescale 1ns / 1ps
module hsl_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [hsl_pkg::LVL_W-1:0]     red_level,
	input logic [hsl_pkg::LVL_W-1:0]     green_level,
	input logic [hsl_pkg::LVL_W-1:0]     blue_level
);

	logic [4:0] inflight_q;
	logic       in_xfer;
	logic       out_xfer;

	assign in_xfer  = in_valid && in_ready;
	assign out_xfer = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			inflight_q <= inflight_q + 5'(in_xfer) - 5'(out_xfer);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(red_level) && $stable(green_level)
			&& $stable(blue_level))
		else $error("result changed while stalled");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> inflight_q != 5'd0)
		else $error("result without a pending input");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= 5'(hsl_pkg::NUM_STAGES))
		else $error("more colors in flight than pipeline stages");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without output backpressure");

endmodule

bind hsl_to_rgb_converter_top hsl_checker u_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (hsl.valid),
	.in_ready    (hsl.ready),
	.out_valid   (rgb.valid),
	.out_ready   (rgb.ready),
	.red_level   (rgb.red_level),
	.green_level (rgb.green_level),
	.blue_level  (rgb.blue_level)
);
